>>> rtl/acpe_pkg.sv
`default_nettype none
package acpe_pkg;

    localparam int BLK_BYTES = 16;
    localparam int RK_DEPTH  = 22;
    localparam int LAST_RND  = 10;

    typedef logic [127:0] t_blk;
    typedef logic [7:0]   t_sbox_tab [0:255];

    // configuration register indexes
    localparam logic [2:0] CFG_KEY_HIGH = 3'd0;
    localparam logic [2:0] CFG_KEY_LOW  = 3'd1;
    localparam logic [2:0] CFG_IV_HIGH  = 3'd2;
    localparam logic [2:0] CFG_IV_LOW   = 3'd3;
    localparam logic [2:0] CFG_DIR      = 3'd4;

    function automatic logic [7:0] f_gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ x;
            x = x[7] ? ({x[6:0], 1'b0} ^ 8'h1b) : {x[6:0], 1'b0};
        end
        return p;
    endfunction

    function automatic logic [7:0] f_gf_inv(input logic [7:0] x);
        logic [7:0] r;
        logic [7:0] base;
        logic [7:0] e;
        r    = 8'h01;
        base = x;
        e    = 8'd254;
        for (int i = 0; i < 8; i++) begin
            if (e[i]) r = f_gmul(r, base);
            base = f_gmul(base, base);
        end
        return r;
    endfunction

    function automatic logic [7:0] f_rotl(input logic [7:0] v, input int n);
        return 8'((v << n) | (v >> (8 - n)));
    endfunction

    // tables are built at elaboration
    function automatic t_sbox_tab f_build_sbox(input logic inv);
        t_sbox_tab t;
        logic [7:0] x;
        logic [7:0] b;
        for (int i = 0; i < 256; i++) begin
            x = 8'(i);
            if (inv) begin
                t[i] = f_gf_inv(f_rotl(x, 1) ^ f_rotl(x, 3) ^ f_rotl(x, 6) ^ 8'h05);
            end else begin
                b = f_gf_inv(x);
                t[i] = b ^ f_rotl(b, 1) ^ f_rotl(b, 2) ^ f_rotl(b, 3) ^ f_rotl(b, 4) ^ 8'h63;
            end
        end
        return t;
    endfunction

    localparam t_sbox_tab SBOX     = f_build_sbox(1'b0);
    localparam t_sbox_tab INV_SBOX = f_build_sbox(1'b1);

    function automatic logic [7:0] f_rcon(input logic [3:0] rnd);
        logic [7:0] r;
        case (rnd)
            4'd0:    r = 8'h01;
            4'd1:    r = 8'h02;
            4'd2:    r = 8'h04;
            4'd3:    r = 8'h08;
            4'd4:    r = 8'h10;
            4'd5:    r = 8'h20;
            4'd6:    r = 8'h40;
            4'd7:    r = 8'h80;
            4'd8:    r = 8'h1b;
            4'd9:    r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_blk f_key_next(input t_blk k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t  = {SBOX[k[23:16]] ^ rc, SBOX[k[15:8]], SBOX[k[7:0]], SBOX[k[31:24]]};
        w0 = k[127:96] ^ t;
        w1 = k[95:64] ^ w0;
        w2 = k[63:32] ^ w1;
        w3 = k[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    function automatic t_blk f_sub_bytes(input t_blk s, input logic inv);
        t_blk o;
        for (int i = 0; i < BLK_BYTES; i++)
            o[127-8*i -: 8] = inv ? INV_SBOX[s[127-8*i -: 8]] : SBOX[s[127-8*i -: 8]];
        return o;
    endfunction

    function automatic t_blk f_shift_rows(input t_blk s, input logic inv);
        t_blk o;
        int src;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                src = inv ? (r + 4 * ((c - r + 4) % 4)) : (r + 4 * ((c + r) % 4));
                o[127-8*(r+4*c) -: 8] = s[127-8*src -: 8];
            end
        return o;
    endfunction

    function automatic t_blk f_mix_columns(input t_blk s, input logic inv);
        t_blk o;
        logic [7:0] m [0:3];
        logic [7:0] acc;
        if (inv) begin
            m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
        end else begin
            m[0] = 8'd2;  m[1] = 8'd3;  m[2] = 8'd1;  m[3] = 8'd1;
        end
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc = acc ^ f_gmul(m[(k - r + 4) % 4], s[127-8*(4*c+k) -: 8]);
                o[127-8*(4*c+r) -: 8] = acc;
            end
        return o;
    endfunction

endpackage
`default_nettype wire

>>> rtl/acpe_if.sv
`default_nettype none
interface acpe_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  byte_count;
    logic        message_end;
    modport source(output valid, block_high, block_low, byte_count, message_end, input ready);
    modport sink(input valid, block_high, block_low, byte_count, message_end, output ready);
endinterface

interface acpe_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_count;
    logic        result_last;
    logic        pad_error;
    modport source(output valid, result_high, result_low, result_count, result_last,
                   pad_error, input ready);
    modport sink(input valid, result_high, result_low, result_count, result_last,
                 pad_error, output ready);
endinterface
`default_nettype wire

>>> rtl/acpe_round.sv
`default_nettype none
// One cipher step: initial key add, middle round or final round.
module acpe_round (
    input  wire acpe_pkg::t_blk i_state,
    input  wire acpe_pkg::t_blk i_rkey,
    input  wire                 i_dec,
    input  wire                 i_first,
    input  wire                 i_last,
    output acpe_pkg::t_blk      o_state
);
    acpe_pkg::t_blk w_enc;
    acpe_pkg::t_blk w_dec;

    always_comb begin
        w_enc = acpe_pkg::f_shift_rows(acpe_pkg::f_sub_bytes(i_state, 1'b0), 1'b0);
        if (!i_last) w_enc = acpe_pkg::f_mix_columns(w_enc, 1'b0);
        w_enc = w_enc ^ i_rkey;

        w_dec = acpe_pkg::f_sub_bytes(acpe_pkg::f_shift_rows(i_state, 1'b1), 1'b1) ^ i_rkey;
        if (!i_last) w_dec = acpe_pkg::f_mix_columns(w_dec, 1'b1);

        if (i_first)    o_state = i_state ^ i_rkey;
        else if (i_dec) o_state = w_dec;
        else            o_state = w_enc;
    end
endmodule
`default_nettype wire

>>> rtl/acpe_keystore.sv
`default_nettype none
// Round key memory (22 x 64) with its expansion sequencer; two read ports.
module acpe_keystore (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire acpe_pkg::t_blk i_key,
    output logic                o_busy,
    input  wire [3:0]           i_rd_round,
    output acpe_pkg::t_blk      o_rkey
);
    logic [63:0]    r_mem [0:acpe_pkg::RK_DEPTH-1];
    logic           r_busy;
    logic [4:0]     r_widx;
    acpe_pkg::t_blk r_kw;
    logic [63:0]    r_rd_hi;
    logic [63:0]    r_rd_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_widx <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_widx <= '0;
        end else if (r_busy) begin
            r_widx <= r_widx + 5'd1;
            if (r_widx == 5'(acpe_pkg::RK_DEPTH - 1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_kw <= i_key;
        end else if (r_busy) begin
            r_mem[r_widx] <= r_widx[0] ? r_kw[63:0] : r_kw[127:64];
            if (r_widx[0]) r_kw <= acpe_pkg::f_key_next(r_kw, acpe_pkg::f_rcon(r_widx[4:1]));
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_hi <= r_mem[{i_rd_round, 1'b0}];
        r_rd_lo <= r_mem[{i_rd_round, 1'b1}];
    end

    assign o_busy = r_busy;
    assign o_rkey = {r_rd_hi, r_rd_lo};
endmodule
`default_nettype wire

>>> rtl/aes128_cbc_pkcs7_engine.sv
`default_nettype none
// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   block_high, block_low, byte_count, message_end
// o_out     out  valid/ready   result_high, result_low, result_count, result_last, pad_error
// i_cfg     in   i_cfg_we      i_cfg_idx, i_cfg_wdata (no read-back)
//
// A block passes through load, 11 round steps and result; the next request is
// taken only once the engine is back in idle and the result is in the output register.
// The first block of a message adds key expansion before it, one memory word
// per cycle. Rate is set by the single shared round unit and the CBC chain.
// Reset is synchronous, active low; round key memory is not cleared.
// A result waits in the output register; the next request is taken meanwhile.
module aes128_cbc_pkcs7_engine (
    input  wire         i_clk,
    input  wire         i_rst_n,
    acpe_in_if.sink     i_in,
    acpe_out_if.source  o_out,
    input  wire         i_cfg_we,
    input  wire [2:0]   i_cfg_idx,
    input  wire [63:0]  i_cfg_wdata
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEYX = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_RUN  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    // config registers
    logic [63:0] r_key_hi, r_key_lo, r_iv_hi, r_iv_lo;
    logic        r_dir_cfg;

    logic [2:0]     r_state;
    logic [3:0]     r_step;
    logic           r_msg_start;
    logic           r_dir;
    logic           r_end;
    logic           r_extra;
    acpe_pkg::t_blk r_blk;
    acpe_pkg::t_blk r_s;
    acpe_pkg::t_blk r_chain;

    logic           r_ovalid;
    logic [63:0]    r_ohi, r_olo;
    logic [4:0]     r_ocnt;
    logic           r_olast, r_oerr;

    logic           w_accept;
    logic           w_ks_busy;
    logic [3:0]     w_rd_step;
    logic [3:0]     w_rd_round;
    acpe_pkg::t_blk w_rkey;
    acpe_pkg::t_blk n_s;
    acpe_pkg::t_blk w_in_blk;
    acpe_pkg::t_blk w_padded;
    logic [4:0]     w_cnt;
    logic [4:0]     w_pad;
    acpe_pkg::t_blk w_res;
    logic [7:0]     w_pval;
    logic           w_pad_ok;
    logic           w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi  <= '0;
            r_key_lo  <= '0;
            r_iv_hi   <= '0;
            r_iv_lo   <= '0;
            r_dir_cfg <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                acpe_pkg::CFG_KEY_HIGH: r_key_hi  <= i_cfg_wdata;
                acpe_pkg::CFG_KEY_LOW:  r_key_lo  <= i_cfg_wdata;
                acpe_pkg::CFG_IV_HIGH:  r_iv_hi   <= i_cfg_wdata;
                acpe_pkg::CFG_IV_LOW:   r_iv_lo   <= i_cfg_wdata;
                acpe_pkg::CFG_DIR:      r_dir_cfg <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;

    // saturate the count, PKCS#7 fill of a short last encrypt block
    assign w_in_blk = {i_in.block_high, i_in.block_low};
    assign w_cnt    = (i_in.byte_count > 5'd16) ? 5'd16 : i_in.byte_count;
    assign w_pad    = 5'd16 - w_cnt;
    always_comb begin
        w_padded = w_in_blk;
        for (int p = 0; p < acpe_pkg::BLK_BYTES; p++)
            if (i_in.message_end && !r_dir_cfg && (5'(p) >= w_cnt))
                w_padded[127-8*p -: 8] = {3'b000, w_pad};
    end

    // key order reverses for decryption; read one step ahead
    assign w_rd_step  = (r_state == ST_RUN) ? r_step + 4'd1 : 4'd0;
    assign w_rd_round = r_dir ? 4'(acpe_pkg::LAST_RND) - w_rd_step : w_rd_step;

    acpe_keystore u_keys (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept && r_msg_start),
        .i_key      ({r_key_hi, r_key_lo}),
        .o_busy     (w_ks_busy),
        .i_rd_round (w_rd_round),
        .o_rkey     (w_rkey)
    );

    acpe_round u_round (
        .i_state (r_s),
        .i_rkey  (w_rkey),
        .i_dec   (r_dir),
        .i_first (r_step == 4'd0),
        .i_last  (r_step == 4'(acpe_pkg::LAST_RND)),
        .o_state (n_s)
    );

    // result and pad check
    assign w_res  = r_dir ? (r_s ^ r_chain) : r_s;
    assign w_pval = w_res[7:0];
    always_comb begin
        w_pad_ok = (w_pval >= 8'd1) && (w_pval <= 8'd16);
        for (int p = 0; p < acpe_pkg::BLK_BYTES; p++)
            if ((5'(p) >= 5'd16 - w_pval[4:0]) && (w_res[127-8*p -: 8] != w_pval))
                w_pad_ok = 1'b0;
    end

    assign w_out_free = !r_ovalid || o_out.ready;

    // output register valid: loaded from DONE, emptied when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == ST_DONE) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_msg_start <= 1'b1;
            r_extra     <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state     <= r_msg_start ? ST_KEYX : ST_LOAD;
                        r_msg_start <= i_in.message_end;
                        r_extra     <= i_in.message_end && !r_dir_cfg && (w_cnt == 5'd16);
                    end
                end
                ST_KEYX: begin
                    if (!w_ks_busy) r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    r_step  <= '0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'(acpe_pkg::LAST_RND)) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_extra  <= 1'b0;
                        r_state  <= r_extra ? ST_LOAD : ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_blk <= w_padded;
                    r_dir <= r_dir_cfg;
                    r_end <= i_in.message_end;
                    if (r_msg_start) r_chain <= {r_iv_hi, r_iv_lo};
                end
            end
            ST_LOAD: r_s <= r_dir ? r_blk : (r_blk ^ r_chain);
            ST_RUN:  r_s <= n_s;
            ST_DONE: begin
                if (w_out_free) begin
                    r_chain <= r_dir ? r_blk : r_s;
                    r_blk   <= {acpe_pkg::BLK_BYTES{8'h10}};
                    if (r_dir && r_end && !w_pad_ok) begin
                        r_ohi  <= '0;
                        r_olo  <= '0;
                        r_ocnt <= 5'd0;
                        r_oerr <= 1'b1;
                    end else begin
                        r_ohi  <= w_res[127:64];
                        r_olo  <= w_res[63:0];
                        r_ocnt <= (r_dir && r_end) ? 5'd16 - w_pval[4:0] : 5'd16;
                        r_oerr <= 1'b0;
                    end
                    r_olast <= r_end && !r_extra;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.result_high  = r_ohi;
    assign o_out.result_low   = r_olo;
    assign o_out.result_count = r_ocnt;
    assign o_out.result_last  = r_olast;
    assign o_out.pad_error    = r_oerr;

    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.pad_error |-> o_out.result_last && (o_out.result_count == 5'd0))
        else $error("pad error result malformed");

    a_mid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.result_last |-> (o_out.result_count == 5'd16))
        else $error("non-final result not full");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && (r_step == 4'(acpe_pkg::LAST_RND)) |=> (r_state == ST_DONE))
        else $error("round sequence overran");

    a_keyx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && r_msg_start |=> (r_state == ST_KEYX) && w_ks_busy)
        else $error("key expansion not started at message start");
endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
    import acpe_pkg::*;

    typedef bit [127:0] blk_t;

    // one result as seen on the output channel
    typedef struct {
        blk_t     data;
        bit [4:0] count;
        bit       last;
        bit       err;
    } result_t;

    // AES-128 CBC/PKCS#7 predictor plus store of expected result blocks
    class cbc_scoreboard;
        bit [7:0] fwd_tab [256];
        bit [7:0] inv_tab [256];
        bit [63:0] key_hi, key_lo, iv_hi, iv_lo;
        bit        decrypt;
        blk_t      keys [11];
        blk_t      chain;
        bit        at_msg_start;
        result_t   expected_blocks [$];
        int        errors;
        int        results_seen;
        int        requests_seen;

        function new();
            bit [7:0] r, base, x;
            for (int v = 0; v < 256; v++) begin
                x = v;
                r = 1;
                base = x;
                for (int i = 1; i < 8; i++) begin
                    base = gmul(base, base);
                    r = gmul(r, base);
                end
                // x^254 is the field inverse, then the affine map
                fwd_tab[v] = r ^ rotl(r, 1) ^ rotl(r, 2) ^ rotl(r, 3) ^ rotl(r, 4) ^ 8'h63;
                inv_tab[fwd_tab[v]] = x;
            end
            at_msg_start = 1;
        endfunction

        function bit [7:0] rotl(bit [7:0] v, int n);
            return (v << n) | (v >> (8 - n));
        endfunction

        function bit [7:0] gmul(bit [7:0] a, bit [7:0] b);
            bit [7:0] p;
            p = 0;
            for (int i = 0; i < 8; i++) begin
                if (b[i]) p ^= a;
                a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
            end
            return p;
        endfunction

        function void write_reg(bit [2:0] idx, bit [63:0] val);
            case (idx)
                CFG_KEY_HIGH: key_hi = val;
                CFG_KEY_LOW:  key_lo = val;
                CFG_IV_HIGH:  iv_hi = val;
                CFG_IV_LOW:   iv_lo = val;
                CFG_DIR:      decrypt = val[0];
                default: ;
            endcase
        endfunction

        function void expand(output blk_t ks [11]);
            bit [7:0]  rc;
            bit [31:0] t, w0, w1, w2, w3;
            blk_t      k;
            k = {key_hi, key_lo};
            ks[0] = k;
            rc = 1;
            for (int i = 1; i < 11; i++) begin
                t = {fwd_tab[k[23:16]] ^ rc, fwd_tab[k[15:8]], fwd_tab[k[7:0]],
                     fwd_tab[k[31:24]]};
                w0 = k[127:96] ^ t;
                w1 = k[95:64] ^ w0;
                w2 = k[63:32] ^ w1;
                w3 = k[31:0] ^ w2;
                k = {w0, w1, w2, w3};
                ks[i] = k;
                rc = gmul(rc, 2);
            end
        endfunction

        function blk_t subst(blk_t s, bit inv);
            for (int i = 0; i < 16; i++)
                s[127-8*i -: 8] = inv ? inv_tab[s[127-8*i -: 8]] : fwd_tab[s[127-8*i -: 8]];
            return s;
        endfunction

        function blk_t shift(blk_t s, bit inv);
            blk_t t;
            int   src;
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) begin
                    src = inv ? r + 4 * ((c - r + 4) % 4) : r + 4 * ((c + r) % 4);
                    t[127-8*(r+4*c) -: 8] = s[127-8*src -: 8];
                end
            return t;
        endfunction

        function blk_t mix(blk_t s, bit inv);
            blk_t     t;
            bit [7:0] m [4];
            bit [7:0] acc;
            if (inv) begin
                m[0] = 8'd14; m[1] = 8'd11; m[2] = 8'd13; m[3] = 8'd9;
            end else begin
                m[0] = 8'd2;  m[1] = 8'd3;  m[2] = 8'd1;  m[3] = 8'd1;
            end
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        acc ^= gmul(m[(k - r + 4) % 4], s[127-8*(4*c+k) -: 8]);
                    t[127-8*(4*c+r) -: 8] = acc;
                end
            return t;
        endfunction

        function blk_t encipher(blk_t s, blk_t ks [11]);
            s ^= ks[0];
            for (int r = 1; r <= 10; r++) begin
                s = shift(subst(s, 0), 0);
                if (r < 10) s = mix(s, 0);
                s ^= ks[r];
            end
            return s;
        endfunction

        function blk_t decipher(blk_t s, blk_t ks [11]);
            s ^= ks[10];
            for (int r = 9; r >= 0; r--) begin
                s = subst(shift(s, 1), 1) ^ ks[r];
                if (r > 0) s = mix(s, 1);
            end
            return s;
        endfunction

        // CBC-encrypt a plaintext message in place with the current key and IV,
        // used to build ciphertext for the decrypt direction
        function void seal(ref blk_t msg [$]);
            blk_t ks [11];
            blk_t c;
            expand(ks);
            c = {iv_hi, iv_lo};
            foreach (msg[i]) begin
                c = encipher(msg[i] ^ c, ks);
                msg[i] = c;
            end
        endfunction

        function void push(blk_t d, bit [4:0] cnt, bit last, bit err);
            result_t r;
            r.data = d;
            r.count = cnt;
            r.last = last;
            r.err = err;
            expected_blocks.push_back(r);
        endfunction

        function blk_t chain_encrypt(blk_t b);
            chain = encipher(b ^ chain, keys);
            return chain;
        endfunction

        function void note_request(blk_t b, bit [4:0] cnt, bit msg_end);
            int       n;
            bit [7:0] pad;
            bit       ok;
            blk_t     prev;
            requests_seen++;
            n = (cnt > 16) ? 16 : cnt;
            if (at_msg_start) begin
                expand(keys);
                chain = {iv_hi, iv_lo};
                at_msg_start = 0;
            end
            if (!decrypt) begin
                if (!msg_end) begin
                    push(chain_encrypt(b), 16, 0, 0);
                end else if (n < 16) begin
                    at_msg_start = 1;
                    for (int i = n; i < 16; i++) b[127-8*i -: 8] = 16 - n;
                    push(chain_encrypt(b), 16, 1, 0);
                end else begin
                    // full last block: data block then a whole pad block
                    at_msg_start = 1;
                    push(chain_encrypt(b), 16, 0, 0);
                    push(chain_encrypt({16{8'h10}}), 16, 1, 0);
                end
            end else begin
                prev = chain;
                chain = b;
                b = decipher(b, keys) ^ prev;
                if (!msg_end) begin
                    push(b, 16, 0, 0);
                end else begin
                    at_msg_start = 1;
                    pad = b[7:0];
                    ok = (pad >= 1 && pad <= 16);
                    for (int i = 0; i < 16; i++)
                        if (ok && i < pad && b[8*i +: 8] != pad) ok = 0;
                    if (ok) push(b, 16 - pad, 1, 0);
                    else push('0, 0, 1, 1);
                end
            end
        endfunction

        function void report(string what);
            if (errors < 40) $display("mismatch: %s", what);
            errors++;
        endfunction

        function void check_result(result_t got);
            result_t want;
            results_seen++;
            if (expected_blocks.size() == 0) begin
                report($sformatf("unexpected result %h", got.data));
                return;
            end
            want = expected_blocks.pop_front();
            if (got.data !== want.data)
                report($sformatf("result #%0d data %h, want %h", results_seen, got.data,
                                 want.data));
            if (got.count !== want.count)
                report($sformatf("result #%0d count %0d, want %0d", results_seen, got.count,
                                 want.count));
            if (got.last !== want.last)
                report($sformatf("result #%0d last %b, want %b", results_seen, got.last,
                                 want.last));
            if (got.err !== want.err)
                report($sformatf("result #%0d pad_error %b, want %b", results_seen, got.err,
                                 want.err));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [63:0] i_cfg_wdata;

    acpe_in_if  in_if ();
    acpe_out_if out_if ();

    aes128_cbc_pkcs7_engine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    cbc_scoreboard sb = new();

    int send_idle_pct;   // chance per cycle the sender holds off
    int recv_stall_pct;  // chance per cycle the receiver is not ready
    int enc_msgs, dec_msgs, bad_pads;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #20000000;
        $display("timeout: %0d results still outstanding", sb.expected_blocks.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // result side: random backpressure, compare every accepted result
    always @(posedge i_clk) begin
        result_t got;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.data = {out_if.result_high, out_if.result_low};
            got.count = out_if.result_count;
            got.last = out_if.result_last;
            got.err = out_if.pad_error;
            sb.check_result(got);
        end
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // present one request, hold it until taken
    task automatic send_block(blk_t b, bit [4:0] cnt, bit msg_end);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 0;
            @(posedge i_clk);
        end
        in_if.valid <= 1;
        in_if.block_high <= b[127:64];
        in_if.block_low <= b[63:0];
        in_if.byte_count <= cnt;
        in_if.message_end <= msg_end;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_request(b, cnt, msg_end);
    endtask

    // quiet the request side, let all results come out, then let the core settle
    task automatic drain();
        in_if.valid <= 0;
        while (sb.expected_blocks.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // write all five registers back to back; we stays high across the burst
    task automatic load_setup(bit [63:0] kh, bit [63:0] kl, bit [63:0] vh, bit [63:0] vl,
                              bit dir);
        bit [63:0] vals [5];
        vals = '{kh, kl, vh, vl, {63'b0, dir}};
        for (int i = 0; i < 5; i++) begin
            i_cfg_we <= 1;
            i_cfg_idx <= 3'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            sb.write_reg(3'(i), vals[i]);
        end
        i_cfg_we <= 0;
    endtask

    function automatic blk_t rand_blk();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // encrypt direction: last byte count picked by caller (values above 16 saturate)
    task automatic encrypt_msg(int nblk, bit [4:0] last_cnt);
        for (int i = 0; i < nblk - 1; i++)
            send_block(rand_blk(), 5'($urandom_range(31)), 0);
        send_block(rand_blk(), last_cnt, 1);
        enc_msgs++;
    endtask

    // decrypt direction: build padded plaintext, encrypt it here, send ciphertext.
    // kind 0 good pad, 1 pad value zero, 2 pad above 16, 3 one pad byte wrong,
    // 4 raw random ciphertext
    task automatic decrypt_msg(int nblk, int pad, int kind);
        blk_t msg [$];
        blk_t t;
        for (int i = 0; i < nblk; i++) msg.push_back(rand_blk());
        t = msg[nblk-1];
        case (kind)
            0, 3: begin
                for (int i = 0; i < pad; i++) t[8*i +: 8] = pad;
                if (kind == 3) t[8*(pad-1) +: 8] ^= 8'(1 << $urandom_range(7));
            end
            1: t[7:0] = 0;
            2: t[7:0] = 8'($urandom_range(255, 17));
            default: ;
        endcase
        msg[nblk-1] = t;
        if (kind != 4) sb.seal(msg);
        else msg[nblk-1] = rand_blk();
        if (kind != 0) bad_pads++;
        for (int i = 0; i < nblk; i++)
            send_block(msg[i], 5'($urandom_range(31)), i == nblk - 1);
        dec_msgs++;
    endtask

    initial begin
        int target;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n <= 0;
        i_cfg_we <= 0;
        i_cfg_idx <= CFG_KEY_HIGH;
        i_cfg_wdata <= 0;
        in_if.valid <= 0;
        in_if.block_high <= 0;
        in_if.block_low <= 0;
        in_if.byte_count <= 0;
        in_if.message_end <= 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: all-zero key and IV, padding corners on the encrypt side
        load_setup('0, '0, '0, '0, 0);
        send_block('0, 0, 1);            // empty last block -> all pad bytes
        send_block('1, 16, 1);           // full last block -> extra pad block
        send_block('1, 31, 1);           // oversize count saturates
        send_block(rand_blk(), 15, 1);   // single pad byte
        send_block(rand_blk(), 1, 1);
        encrypt_msg(3, 5'd7);
        drain();
        // directed decrypt with all-ones key and IV
        load_setup('1, '1, '1, '1, 1);
        decrypt_msg(1, 16, 0);           // whole block of padding
        decrypt_msg(1, 1, 0);            // shortest pad
        decrypt_msg(2, 9, 0);
        decrypt_msg(1, 1, 1);            // pad value zero
        decrypt_msg(1, 1, 2);            // pad value too large
        decrypt_msg(2, 16, 3);           // bad byte inside the pad run
        decrypt_msg(1, 1, 4);
        drain();

        // random phases: idle mode x register setting
        for (int mode = 0; mode < 4; mode++) begin
            for (int setting = 0; setting < 4; setting++) begin
                send_idle_pct = (mode == 1) ? 88 : (mode == 3) ? 26 : 0;
                recv_stall_pct = (mode == 2) ? 88 : (mode == 3) ? 26 : 0;
                case (setting)
                    0: load_setup('0, '1, '1, '0, 0);
                    1: load_setup('1, '0, '0, '1, 1);
                    default: load_setup({$urandom, $urandom}, {$urandom, $urandom},
                                        {$urandom, $urandom}, {$urandom, $urandom},
                                        setting[0]);
                endcase
                target = sb.requests_seen + 112;
                while (sb.requests_seen < target) begin
                    if (!sb.decrypt) begin
                        encrypt_msg($urandom_range(4, 1),
                                    ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17))
                                                             : 5'($urandom_range(16)));
                    end else if ($urandom_range(4) != 0) begin
                        decrypt_msg($urandom_range(4, 1), $urandom_range(16, 1), 0);
                    end else begin
                        decrypt_msg($urandom_range(3, 1), $urandom_range(16, 1),
                                    $urandom_range(4, 1));
                    end
                end
                drain();
            end
        end

        $display("sent %0d requests in %0d encrypt and %0d decrypt messages",
                 sb.requests_seen, enc_msgs, dec_msgs);
        $display("checked %0d results, %0d messages with broken padding, %0d mismatches",
                 sb.results_seen, bad_pads, sb.errors);
        if (sb.errors == 0 && sb.expected_blocks.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> aes128_cbc_pkcs7_engine.f
rtl/acpe_pkg.sv
rtl/acpe_if.sv
rtl/acpe_round.sv
rtl/acpe_keystore.sv
rtl/aes128_cbc_pkcs7_engine.sv
tb/testbench.sv
